/* rtl/etscn_pkg.sv */
// Shared types and constants of the expression token scanner.
package etscn_pkg;

  // Token kind codes
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_ERR     = 5'd1;
  localparam logic [4:0] KIND_LPAREN  = 5'd2;
  localparam logic [4:0] KIND_RPAREN  = 5'd3;
  localparam logic [4:0] KIND_PLUS    = 5'd4;
  localparam logic [4:0] KIND_MINUS   = 5'd5;
  localparam logic [4:0] KIND_MUL     = 5'd6;
  localparam logic [4:0] KIND_DIV     = 5'd7;
  localparam logic [4:0] KIND_POW     = 5'd8;
  localparam logic [4:0] KIND_NUM     = 5'd9;
  localparam logic [4:0] KIND_BIN     = 5'd10;
  localparam logic [4:0] KIND_LESS    = 5'd11;
  localparam logic [4:0] KIND_GREATER = 5'd12;
  localparam logic [4:0] KIND_EQUAL   = 5'd13;
  localparam logic [4:0] KIND_DIF     = 5'd14;
  localparam logic [4:0] KIND_SIN     = 5'd15;
  localparam logic [4:0] KIND_COS     = 5'd16;
  localparam logic [4:0] KIND_LOG     = 5'd17;
  localparam logic [4:0] KIND_TRUE    = 5'd18;
  localparam logic [4:0] KIND_FALSE   = 5'd19;

  // Special characters
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_HASH = "#";
  localparam logic [7:0] CH_B    = "b";
  localparam logic [7:0] CH_CARET = "^";
  localparam logic [7:0] CH_BANG = "!";
  localparam logic [7:0] CH_EQ   = "=";

  // Keyword table: SIN sin COS cos LOG log TRUE true True FALSE false False
  localparam int unsigned KW_NUM = 12;
  localparam logic [7:0] KW_TEXT [KW_NUM][5] = '{
    '{"S", "I", "N", 8'h00, 8'h00},
    '{"s", "i", "n", 8'h00, 8'h00},
    '{"C", "O", "S", 8'h00, 8'h00},
    '{"c", "o", "s", 8'h00, 8'h00},
    '{"L", "O", "G", 8'h00, 8'h00},
    '{"l", "o", "g", 8'h00, 8'h00},
    '{"T", "R", "U", "E", 8'h00},
    '{"t", "r", "u", "e", 8'h00},
    '{"T", "r", "u", "e", 8'h00},
    '{"F", "A", "L", "S", "E"},
    '{"f", "a", "l", "s", "e"},
    '{"F", "a", "l", "s", "e"}
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5
  };
  localparam logic [4:0] KW_KIND [KW_NUM] = '{
    KIND_SIN, KIND_SIN, KIND_COS, KIND_COS, KIND_LOG, KIND_LOG,
    KIND_TRUE, KIND_TRUE, KIND_TRUE, KIND_FALSE, KIND_FALSE, KIND_FALSE
  };

  // One result beat
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  chr;
    logic        last;
  } token_t;

  // Results produced by one input beat, in order
  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

/* rtl/expression_token_scanner.sv */
// Expression token scanner: one character per beat in, tokens out.
// Tokens are registered in the result queue and offered from its head in order.
// Throughput: one character per cycle while the four-entry result queue holds at most two
// tokens; output drains one token per cycle while the receiver is ready.
// Reset: asynchronous, active low; scanner idle, position zero, result queue empty.
module expression_token_scanner #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [7:0]  token_char_o,
  output logic        last_of_run_o
);
  import etscn_pkg::*;

  logic   fire;
  push_t  push;
  token_t out_tok;

  assign fire = in_valid_i && in_ready_o;

  // Scanner
  etscn_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .char_i    (char_in_i),
    .restart_i (restart_i),
    .push_o    (push)
  );

  // Result queue
  etscn_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_tok_o   (out_tok)
  );

  assign token_kind_o   = out_tok.kind;
  assign token_start_o  = out_tok.start;
  assign token_length_o = out_tok.length;
  assign token_char_o   = out_tok.chr;
  assign last_of_run_o  = out_tok.last;

`ifndef SYNTHESIS
  // Nothing is produced without an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0) |-> fire)
    else $error("tokens pushed without an input beat");

  // Only the final token of a pair carries the last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (!push.tok0.last && push.tok1.last))
    else $error("last flag misplaced on token pair");

  // The output is valid in the cycle after any push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != 2'd0) |=> out_valid_o)
    else $error("pushed token not offered");

  // A single token is always the last one of its character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd1) |-> push.tok0.last)
    else $error("single token missing last flag");
`endif

endmodule

/* rtl/etscn_core.sv */
// Scanner state machine: turns one character into zero, one or two tokens.
module etscn_core #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       char_i,
  input  logic             restart_i,
  output etscn_pkg::push_t push_o
);
  import etscn_pkg::*;

  localparam int unsigned LW = POSITION_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NUM, ST_ZERO, ST_BIN, ST_REL, ST_WORD, ST_HALT
  } scan_state_e;

  scan_state_e             st_q, st_d, st;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pos;
  logic [POSITION_BITS-1:0] tsp_q, tsp_d, tsp;
  logic [KW_NUM-1:0]        cand_q, cand_d, cand;
  logic [2:0]               wl_q, wl_d, wl;

  logic        is_digit, is_alpha, is_space, is_bit;
  logic        emit_a, emit_b, do_start, kw_hit;
  token_t      tok_a, tok_b;
  logic [4:0]  kw_kind;
  logic [LW-1:0] run_len, rel_len;
  logic [15:0] pos16, tsp16;

  function automatic logic [15:0] sat16(logic [LW-1:0] v);
    if (v > LW'(32'h0000_FFFF)) begin
      return 16'hFFFF;
    end
    return 16'(v);
  endfunction

  // Drop every keyword that does not continue with this letter
  function automatic logic [KW_NUM-1:0] kw_filter(logic [KW_NUM-1:0] cin, logic [2:0] len,
                                                  logic [7:0] c);
    logic [KW_NUM-1:0] r;
    r = cin;
    for (int k = 0; k < KW_NUM; k++) begin
      if (len >= KW_LEN[k]) begin
        r[k] = 1'b0;
      end else if (KW_TEXT[k][len] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // Restart applies before the character is handled
  always_comb begin
    if (restart_i) begin
      st   = ST_IDLE;
      pos  = '0;
      tsp  = '0;
      cand = '1;
      wl   = '0;
    end else begin
      st   = st_q;
      pos  = pos_q;
      tsp  = tsp_q;
      cand = cand_q;
      wl   = wl_q;
    end
  end

  // Character classes
  always_comb begin
    is_digit = char_i inside {["0":"9"]};
    is_alpha = char_i inside {["A":"Z"], ["a":"z"]};
    is_space = char_i inside {" ", 8'h09, 8'h0A, 8'h0D};
    is_bit   = char_i inside {"0", "1"};
  end

  assign run_len = LW'(pos - tsp);
  assign rel_len = run_len + LW'(1);
  assign pos16   = 16'(pos);
  assign tsp16   = 16'(tsp);

  // First surviving keyword whose length equals the word length
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = KIND_ERR;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (cand[k] && (KW_LEN[k] == wl)) begin
        kw_hit  = 1'b1;
        kw_kind = KW_KIND[k];
      end
    end
  end

  // Main scan step
  always_comb begin
    st_d     = st;
    tsp_d    = tsp;
    cand_d   = cand;
    wl_d     = wl;
    pos_d    = pos;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    do_start = 1'b0;
    tok_a    = '0;
    tok_b    = '0;

    // pending token
    case (st)
      ST_NUM: begin
        if (!is_digit) begin
          emit_a   = 1'b1;
          tok_a    = '{KIND_NUM, tsp16, sat16(run_len), 8'h00, 1'b0};
          st_d     = ST_IDLE;
          do_start = 1'b1;
        end
      end
      ST_ZERO: begin
        if (char_i == CH_B) begin
          st_d = ST_BIN;
        end else if (is_digit) begin
          st_d = ST_NUM;
        end else begin
          emit_a   = 1'b1;
          tok_a    = '{KIND_NUM, tsp16, sat16(run_len), 8'h00, 1'b0};
          st_d     = ST_IDLE;
          do_start = 1'b1;
        end
      end
      ST_BIN: begin
        if (!is_bit) begin
          emit_a   = 1'b1;
          tok_a    = '{KIND_BIN, tsp16, sat16(run_len), 8'h00, 1'b0};
          st_d     = ST_IDLE;
          do_start = 1'b1;
        end
      end
      ST_REL: begin
        emit_a = 1'b1;
        if (char_i == CH_EQ) begin
          tok_a = '{KIND_EQUAL, tsp16, sat16(rel_len), 8'h00, 1'b0};
          st_d  = ST_IDLE;
        end else if (char_i == CH_BANG) begin
          tok_a = '{KIND_DIF, tsp16, sat16(rel_len), 8'h00, 1'b0};
          st_d  = ST_IDLE;
        end else begin
          tok_a = '{KIND_ERR, pos16, 16'd1, char_i, 1'b0};
          st_d  = ST_HALT;
        end
      end
      ST_WORD: begin
        if (is_alpha) begin
          cand_d = kw_filter(cand, wl, char_i);
          wl_d   = (wl == 3'd7) ? wl : wl + 3'd1;
        end else begin
          emit_a = 1'b1;
          if (kw_hit) begin
            tok_a    = '{kw_kind, tsp16, sat16(run_len), 8'h00, 1'b0};
            st_d     = ST_IDLE;
            do_start = 1'b1;
          end else begin
            tok_a = '{KIND_ERR, tsp16, sat16(run_len), 8'h00, 1'b0};
            st_d  = ST_HALT;
          end
        end
      end
      ST_IDLE: do_start = 1'b1;
      ST_HALT: st_d = ST_HALT;
      default: st_d = ST_HALT;
    endcase

    // this character opens a new token
    if (do_start && !is_space) begin
      if (char_i == CH_NUL || char_i == CH_HASH) begin
        emit_b = 1'b1;
        tok_b  = '{KIND_END, pos16, 16'd0, 8'h00, 1'b0};
        st_d   = ST_HALT;
      end else begin
        case (char_i)
          "(":      begin emit_b = 1'b1; tok_b.kind = KIND_LPAREN;  end
          ")":      begin emit_b = 1'b1; tok_b.kind = KIND_RPAREN;  end
          "+":      begin emit_b = 1'b1; tok_b.kind = KIND_PLUS;    end
          "-":      begin emit_b = 1'b1; tok_b.kind = KIND_MINUS;   end
          "*":      begin emit_b = 1'b1; tok_b.kind = KIND_MUL;     end
          "/":      begin emit_b = 1'b1; tok_b.kind = KIND_DIV;     end
          CH_CARET: begin emit_b = 1'b1; tok_b.kind = KIND_POW;     end
          "<":      begin emit_b = 1'b1; tok_b.kind = KIND_LESS;    end
          ">":      begin emit_b = 1'b1; tok_b.kind = KIND_GREATER; end
          default: begin
            tsp_d = pos;
            if (char_i == CH_EQ || char_i == CH_BANG) begin
              st_d = ST_REL;
            end else if (is_digit) begin
              st_d = (char_i == "0") ? ST_ZERO : ST_NUM;
            end else if (is_alpha) begin
              st_d   = ST_WORD;
              cand_d = kw_filter('1, 3'd0, char_i);
              wl_d   = 3'd1;
            end else begin
              emit_b     = 1'b1;
              tok_b.kind = KIND_ERR;
              st_d       = ST_HALT;
            end
          end
        endcase
        if (emit_b) begin
          tok_b.start  = pos16;
          tok_b.length = 16'd1;
          tok_b.chr    = char_i;
        end
      end
    end

    // position moves unless halted, and stops at its top
    if (st != ST_HALT && pos != '1) begin
      pos_d = pos + POSITION_BITS'(1);
    end
  end

  // Pack results in order and flag the final one
  always_comb begin
    push_o = '0;
    if (fire_i) begin
      if (emit_a && emit_b) begin
        push_o.n         = 2'd2;
        push_o.tok0      = tok_a;
        push_o.tok1      = tok_b;
        push_o.tok1.last = 1'b1;
      end else if (emit_a || emit_b) begin
        push_o.n         = 2'd1;
        push_o.tok0      = emit_a ? tok_a : tok_b;
        push_o.tok0.last = 1'b1;
      end
    end
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      pos_q  <= '0;
      tsp_q  <= '0;
      cand_q <= '1;
      wl_q   <= '0;
    end else if (fire_i) begin
      st_q   <= st_d;
      pos_q  <= pos_d;
      tsp_q  <= tsp_d;
      cand_q <= cand_d;
      wl_q   <= wl_d;
    end
  end

endmodule

/* rtl/etscn_fifo.sv */
// Four-entry result queue: takes up to two tokens per cycle, hands out one per beat.
module etscn_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  etscn_pkg::push_t  push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output etscn_pkg::token_t out_tok_o
);
  import etscn_pkg::*;

  token_t     mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign room_o      = (cnt_q <= 3'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign out_tok_o   = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[2'(wr_q + 2'd1)] <= push_i.tok1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.n;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_i.n} - {2'b0, pop};
    end
  end

endmodule

/* tb/expression_token_scanner_tb.sv */
// Self-checking testbench of the expression token scanner.
module expression_token_scanner_tb;
  import etscn_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles without any beat before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1800;
  localparam logic [15:0] POS_TOP = 16'hFFFF;

  typedef enum logic [2:0] {
    SC_IDLE, SC_NUM, SC_ZERO, SC_BIN, SC_REL, SC_WORD, SC_HALT
  } scan_state_e;

  // One row of the directed script; typed rows carry their expected token
  typedef struct {
    logic [7:0]  ch;
    bit          rs;
    bit          typed;
    bit          has_tok;
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [7:0]  tchr;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_in_i;
  logic        restart_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  token_kind_o;
  logic [15:0] token_start_o;
  logic [15:0] token_length_o;
  logic [7:0]  token_char_o;
  logic        last_of_run_o;

  expression_token_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_in_i     (char_in_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_start_o (token_start_o),
    .token_length_o(token_length_o),
    .token_char_o  (token_char_o),
    .last_of_run_o (last_of_run_o)
  );

  // Keyword spellings and the kinds they map to
  string keyword_spellings [12] = '{
    "SIN", "sin", "COS", "cos", "LOG", "log",
    "TRUE", "true", "True", "FALSE", "false", "False"
  };
  logic [4:0] keyword_kinds [12] = '{
    KIND_SIN, KIND_SIN, KIND_COS, KIND_COS, KIND_LOG, KIND_LOG,
    KIND_TRUE, KIND_TRUE, KIND_TRUE, KIND_FALSE, KIND_FALSE, KIND_FALSE
  };
  string      op_chars = "()+-*/^<>";
  logic [7:0] blanks [4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};

  // Directed script: every operator, leading zero, bare 0b, keyword, equal/dif,
  // rejected word, halted input, invalid high code, NUL end, bad follower
  script_row_t intro_script [28] = '{
    '{"(", 1, 1, 1, KIND_LPAREN, 16'd0, 16'd1, "("},
    '{")", 0, 1, 1, KIND_RPAREN, 16'd1, 16'd1, ")"},
    '{"0", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"b", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"^", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"0", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"7", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"*", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"l", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"o", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"g", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"/", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"=", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"!", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"<", 0, 1, 1, KIND_LESS, 16'd14, 16'd1, "<"},
    '{">", 0, 1, 1, KIND_GREATER, 16'd15, 16'd1, ">"},
    '{"+", 0, 1, 1, KIND_PLUS, 16'd16, 16'd1, "+"},
    '{"-", 0, 1, 1, KIND_MINUS, 16'd17, 16'd1, "-"},
    '{"!", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"=", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"q", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"x", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"+", 0, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"A", 0, 1, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{8'hFF, 1, 1, 1, KIND_ERR, 16'd0, 16'd1, 8'hFF},
    '{CH_NUL, 1, 1, 1, KIND_END, 16'd0, 16'd0, 8'h00},
    '{"=", 1, 0, 0, KIND_END, 16'd0, 16'd0, 8'h00},
    '{" ", 0, 1, 1, KIND_ERR, 16'd1, 16'd1, " "}
  };

  // Scanner model state
  scan_state_e scan_st;
  logic [15:0] scan_pos;
  logic [15:0] tok_begin;
  logic [11:0] kw_alive;
  logic [2:0]  word_len;

  token_t char_tokens[$];     // tokens caused by the current character
  token_t pending_tokens[$];  // tokens still owed by the block

  int mismatch_count;
  int stim_count;
  int quiet_cycles;
  int rx_stall_left;
  int rx_hold_left;
  bit gaps_on;
  bit hold_req;
  bit restart_next;
  bit restart_noise;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic void clear_scanner();
    scan_st   = SC_IDLE;
    scan_pos  = '0;
    tok_begin = '0;
    kw_alive  = '1;
    word_len  = '0;
  endfunction

  function automatic void add_token(input logic [4:0] kind, input logic [15:0] start,
                                    input int len, input logic [7:0] chr);
    token_t t;
    if (char_tokens.size() >= 2) return;
    t.kind   = kind;
    t.start  = start;
    t.length = (len > 65535) ? 16'hFFFF : len[15:0];
    t.chr    = chr;
    t.last   = 1'b0;
    char_tokens.push_back(t);
  endfunction

  // Narrow the keyword candidates by one more letter
  function automatic void take_letter(input logic [7:0] c);
    for (int k = 0; k < 12; k++) begin
      if (kw_alive[k] && (word_len >= keyword_spellings[k].len() ||
                          keyword_spellings[k][word_len] != c))
        kw_alive[k] = 1'b0;
    end
    if (word_len != 3'd7) word_len++;
  endfunction

  // Emit the finished word; 1 when it was a keyword
  function automatic bit close_word(input logic [15:0] p);
    for (int k = 0; k < 12; k++) begin
      if (kw_alive[k] && keyword_spellings[k].len() == word_len) begin
        add_token(keyword_kinds[k], tok_begin, int'(p) - int'(tok_begin), 8'h00);
        return 1'b1;
      end
    end
    add_token(KIND_ERR, tok_begin, int'(p) - int'(tok_begin), 8'h00);
    return 1'b0;
  endfunction

  // Character seen from the idle state
  function automatic void open_token(input logic [7:0] c, input logic [15:0] p);
    logic [4:0] k;
    bit single;
    if (is_space(c)) return;
    if (c == CH_NUL || c == CH_HASH) begin
      add_token(KIND_END, p, 0, 8'h00);
      scan_st = SC_HALT;
      return;
    end
    single = 1'b1;
    k = KIND_END;
    case (c)
      "(":      k = KIND_LPAREN;
      ")":      k = KIND_RPAREN;
      "+":      k = KIND_PLUS;
      "-":      k = KIND_MINUS;
      "*":      k = KIND_MUL;
      "/":      k = KIND_DIV;
      CH_CARET: k = KIND_POW;
      "<":      k = KIND_LESS;
      ">":      k = KIND_GREATER;
      default:  single = 1'b0;
    endcase
    if (single) begin
      add_token(k, p, 1, c);
      return;
    end
    tok_begin = p;
    if (c == CH_EQ || c == CH_BANG) begin
      scan_st = SC_REL;
    end else if (is_digit(c)) begin
      scan_st = (c == "0") ? SC_ZERO : SC_NUM;
    end else if (is_alpha(c)) begin
      scan_st  = SC_WORD;
      kw_alive = '1;
      word_len = '0;
      take_letter(c);
    end else begin
      add_token(KIND_ERR, p, 1, c);
      scan_st = SC_HALT;
    end
  endfunction

  // Advance the scanner model by one character; 0 when the block ignores it
  function automatic bit predict(input logic [7:0] c, input bit rs);
    logic [15:0] p;
    char_tokens.delete();
    if (rs) clear_scanner();
    if (scan_st == SC_HALT) return 1'b0;
    p = scan_pos;
    case (scan_st)
      SC_NUM: begin
        if (!is_digit(c)) begin
          add_token(KIND_NUM, tok_begin, int'(p) - int'(tok_begin), 8'h00);
          scan_st = SC_IDLE;
          open_token(c, p);
        end
      end
      SC_ZERO: begin
        if (c == CH_B) begin
          scan_st = SC_BIN;
        end else if (is_digit(c)) begin
          scan_st = SC_NUM;
        end else begin
          add_token(KIND_NUM, tok_begin, int'(p) - int'(tok_begin), 8'h00);
          scan_st = SC_IDLE;
          open_token(c, p);
        end
      end
      SC_BIN: begin
        if (c != "0" && c != "1") begin
          add_token(KIND_BIN, tok_begin, int'(p) - int'(tok_begin), 8'h00);
          scan_st = SC_IDLE;
          open_token(c, p);
        end
      end
      SC_REL: begin
        if (c == CH_EQ) begin
          add_token(KIND_EQUAL, tok_begin, int'(p) - int'(tok_begin) + 1, 8'h00);
          scan_st = SC_IDLE;
        end else if (c == CH_BANG) begin
          add_token(KIND_DIF, tok_begin, int'(p) - int'(tok_begin) + 1, 8'h00);
          scan_st = SC_IDLE;
        end else begin
          add_token(KIND_ERR, p, 1, c);
          scan_st = SC_HALT;
        end
      end
      SC_WORD: begin
        if (is_alpha(c)) begin
          take_letter(c);
        end else if (close_word(p)) begin
          scan_st = SC_IDLE;
          open_token(c, p);
        end else begin
          scan_st = SC_HALT;
        end
      end
      SC_IDLE: open_token(c, p);
      default: scan_st = SC_HALT;
    endcase
    if (scan_pos != POS_TOP) scan_pos++;
    if (char_tokens.size() > 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
    return 1'b1;
  endfunction

  // Offer one input beat and hold it until taken
  task automatic send_char(input logic [7:0] c, input bit rs);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    restart_i  <= rs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic put_char(input logic [7:0] c, input bit rs);
    bit rs_eff;
    rs_eff = rs | restart_next | (restart_noise && $urandom_range(0, 149) == 0);
    restart_next = 1'b0;
    send_char(c, rs_eff);
    if (predict(c, rs_eff)) stim_count++;
    foreach (char_tokens[t]) pending_tokens.push_back(char_tokens[t]);
  endtask

  task automatic put_string(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i], 1'b0);
  endtask

  // Let every owed token come out before going on
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);
  endtask

  // One well-formed token, or a near miss of one
  task automatic random_token();
    int n;
    int k;
    string w;
    logic [7:0] base;
    case ($urandom_range(0, 11))
      0, 1, 2: put_char(op_chars[$urandom_range(0, 8)], 1'b0);
      3, 4: begin
        n = $urandom_range(1, 5);
        if ($urandom_range(0, 2) == 0) begin
          put_char("0", 1'b0);
          n--;
        end
        repeat (n) put_char(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
      5: begin
        put_string("0b");
        repeat ($urandom_range(0, 6)) put_char(8'("0" + $urandom_range(0, 1)), 1'b0);
      end
      6, 7: put_string(keyword_spellings[$urandom_range(0, 11)]);
      8: begin
        // keyword with a dropped letter or a flipped case
        w = keyword_spellings[$urandom_range(0, 11)];
        if ($urandom_range(0, 1)) begin
          w = w.substr(0, w.len() - 2);
        end else begin
          k = $urandom_range(0, w.len() - 1);
          w[k] = w[k] ^ 8'h20;
        end
        put_string(w);
      end
      9: begin
        repeat ($urandom_range(1, 9)) begin
          base = "a";
          if ($urandom_range(0, 1)) base = "A";
          put_char(8'(base + $urandom_range(0, 25)), 1'b0);
        end
      end
      10: begin
        put_char($urandom_range(0, 1) ? CH_EQ : CH_BANG, 1'b0);
        put_char($urandom_range(0, 1) ? CH_EQ : CH_BANG, 1'b0);
      end
      default: put_char(blanks[$urandom_range(0, 3)], 1'b0);
    endcase
  endtask

  // One expression from restart to end marker, sometimes broken
  task automatic random_sentence();
    int ntok;
    restart_next = 1'b1;
    gaps_on = ($urandom_range(0, 7) != 0);
    ntok = $urandom_range(1, 12);
    for (int t = 0; t < ntok && scan_st != SC_HALT; t++) begin
      random_token();
      if ($urandom_range(0, 9) < 6) put_char(blanks[$urandom_range(0, 3)], 1'b0);
    end
    if (scan_st != SC_HALT) begin
      case ($urandom_range(0, 9))
        0, 1, 2: put_char(CH_HASH, 1'b0);
        3, 4, 5: put_char(CH_NUL, 1'b0);
        6: put_char(8'($urandom_range(0, 255)), 1'b0);
        7: begin
          put_char($urandom_range(0, 1) ? CH_EQ : CH_BANG, 1'b0);
          put_char(8'($urandom_range(0, 255)), 1'b0);
        end
        default: ;  // left open, next restart cuts it
      endcase
    end
    // noise while halted
    if (scan_st == SC_HALT)
      repeat ($urandom_range(0, 2)) put_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic note_mismatch(input string what, input token_t want, input token_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: want kind %0d start %0d len %0d char %02h last %0b,",
               what, want.kind, want.start, want.length, want.chr, want.last,
               " got kind %0d start %0d len %0d char %02h last %0b",
               got.kind, got.start, got.length, got.chr, got.last);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stall after each beat, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) rx_stall_left = gaps_on ? $urandom_range(0, 5) : 0;
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Token checker
  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{token_kind_o, token_start_o, token_length_o, token_char_o, last_of_run_o};
      if (pending_tokens.size() == 0) begin
        note_mismatch("unexpected token", '0, got);
      end else begin
        want = pending_tokens.pop_front();
        if (got !== want) note_mismatch("token mismatch", want, got);
      end
    end
  end

  // Watchdog on beats in either direction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    token_t typed_tok;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    char_in_i      = 8'h00;
    restart_i      = 1'b0;
    out_ready_i    = 1'b0;
    gaps_on        = 1'b1;
    hold_req       = 1'b0;
    restart_next   = 1'b0;
    restart_noise  = 1'b0;
    mismatch_count = 0;
    stim_count     = 0;
    quiet_cycles   = 0;
    rx_stall_left  = 0;
    rx_hold_left   = 0;
    clear_scanner();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script
    foreach (intro_script[r]) begin
      if (intro_script[r].typed) begin
        send_char(intro_script[r].ch, intro_script[r].rs);
        void'(predict(intro_script[r].ch, intro_script[r].rs));
        if (intro_script[r].has_tok) begin
          typed_tok = '{intro_script[r].kind, intro_script[r].start, intro_script[r].len,
                        intro_script[r].tchr, 1'b1};
          pending_tokens.push_back(typed_tok);
        end
      end else begin
        put_char(intro_script[r].ch, intro_script[r].rs);
      end
    end

    // Random expressions; the receiver holds off early so the block backs up
    hold_req      = 1'b1;
    restart_noise = 1'b1;
    stim_count    = 0;
    while (stim_count < RANDOM_ITEMS) random_sentence();

    // Closing expression sent back to back after a full drain
    wait_drained();
    gaps_on       = 1'b0;
    restart_noise = 1'b0;
    put_char(8'h20, 1'b1);
    put_string("42719");
    put_string("5+==sin(#");

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_tokens.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
